// File: rtl/core/dpp_pkg.sv
package dpp_pkg;

    localparam int DIV_STG = 62;
    localparam int MUL_LAT = 5;
    localparam int SH_Q30  = 30;
    localparam int SH_Q28  = 28;
    localparam int CFG_IW  = 4;

    typedef logic [CFG_IW-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_K1 = 4'd0;
    localparam cfg_idx_t REG_K2 = 4'd1;
    localparam cfg_idx_t REG_K3 = 4'd2;
    localparam cfg_idx_t REG_P1 = 4'd3;
    localparam cfg_idx_t REG_P2 = 4'd4;
    localparam cfg_idx_t REG_FX = 4'd5;
    localparam cfg_idx_t REG_FY = 4'd6;
    localparam cfg_idx_t REG_PP = 4'd7;

    localparam logic [31:0] FOCAL_RST = 32'd65536000;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_ZNEG = 2'd1;
    localparam status_t ST_SAT  = 2'd2;

    // Q30 working value, clamped to +-2^61
    typedef logic signed [62:0] q_t;

    localparam q_t Q_LIM = 63'sh2000_0000_0000_0000;
    localparam q_t Q_ONE = 63'sh0000_0000_4000_0000;
    localparam logic signed [63:0] S_LIM  = 64'sh2000_0000_0000_0000;
    localparam logic signed [63:0] S_NLIM = -64'sh2000_0000_0000_0000;
    localparam logic signed [63:0] PIX_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] PIX_MIN = -64'sh0000_0000_8000_0000;

    typedef struct packed {
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] pixel_x;
        logic signed [31:0] pixel_y;
        status_t            status;
    } out_t;

    typedef struct packed {
        q_t   val;
        logic sat;
    } sres_t;

    typedef struct packed {
        logic               zbad;
        logic               sat;
        q_t                 nx;
        q_t                 ny;
        q_t                 xx;
        q_t                 yy;
        q_t                 xy;
        q_t                 xy2;
        q_t                 r2;
        q_t                 txx;
        q_t                 tyy;
        q_t                 r4;
        q_t                 ax;
        q_t                 ay;
        q_t                 rad;
        q_t                 r6;
        q_t                 t1;
        q_t                 t2;
        q_t                 t3;
        q_t                 t4;
        q_t                 xd;
        q_t                 yd;
        logic signed [31:0] px;
        logic signed [31:0] py;
    } item_t;

    function automatic q_t sx32(logic signed [31:0] v);
        return {{31{v[31]}}, v};
    endfunction

    function automatic sres_t sadd(q_t a, q_t b);
        logic signed [63:0] s;
        sres_t r;
        s = {a[62], a} + {b[62], b};
        if (s > S_LIM) begin
            r.val = Q_LIM;
            r.sat = 1'b1;
        end else if (s < S_NLIM) begin
            r.val = -Q_LIM;
            r.sat = 1'b1;
        end else begin
            r.val = s[62:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/dpp_div.sv
module dpp_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_vld,
    input  logic               in_zbad,
    input  logic signed [31:0] num_x,
    input  logic signed [31:0] num_y,
    input  logic [30:0]        den,
    output logic               out_vld,
    output logic               out_zbad,
    output dpp_pkg::q_t        quo_x,
    output dpp_pkg::q_t        quo_y
);
    import dpp_pkg::*;

    localparam int RW = 31;

    logic [DIV_STG:0]   vld_reg;
    logic [DIV_STG:0]   zbad_reg;
    logic [DIV_STG:0]   negx_reg;
    logic [DIV_STG:0]   negy_reg;
    logic [RW-1:0]      den_reg  [DIV_STG+1];
    logic [RW-1:0]      remx_reg [DIV_STG+1];
    logic [RW-1:0]      remy_reg [DIV_STG+1];
    logic [DIV_STG-1:0] nqx_reg  [DIV_STG+1];
    logic [DIV_STG-1:0] nqy_reg  [DIV_STG+1];
    logic [31:0]        absx;
    logic [31:0]        absy;

    // one restoring step: remainder in the upper part, quotient shifts in below
    function automatic logic [RW+DIV_STG-1:0] div_step(logic [RW-1:0] rem,
                                                       logic [DIV_STG-1:0] nq,
                                                       logic [RW-1:0] d);
        logic [RW:0] tr;
        logic [RW:0] df;
        tr = {rem, nq[DIV_STG-1]};
        df = tr - {1'b0, d};
        if (tr >= {1'b0, d}) begin
            return {df[RW-1:0], nq[DIV_STG-2:0], 1'b1};
        end
        return {tr[RW-1:0], nq[DIV_STG-2:0], 1'b0};
    endfunction

    assign absx = num_x[31] ? 32'(-num_x) : 32'(num_x);
    assign absy = num_y[31] ? 32'(-num_y) : 32'(num_y);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DIV_STG-1:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zbad_reg <= {zbad_reg[DIV_STG-1:0], in_zbad};
            negx_reg <= {negx_reg[DIV_STG-1:0], num_x[31]};
            negy_reg <= {negy_reg[DIV_STG-1:0], num_y[31]};
            den_reg[0]  <= den;
            remx_reg[0] <= '0;
            remy_reg[0] <= '0;
            nqx_reg[0]  <= {absx, 30'd0};
            nqy_reg[0]  <= {absy, 30'd0};
            for (int i = 1; i <= DIV_STG; i++) begin
                den_reg[i] <= den_reg[i-1];
                {remx_reg[i], nqx_reg[i]} <= div_step(remx_reg[i-1], nqx_reg[i-1],
                                                      den_reg[i-1]);
                {remy_reg[i], nqy_reg[i]} <= div_step(remy_reg[i-1], nqy_reg[i-1],
                                                      den_reg[i-1]);
            end
        end
    end

    assign out_vld  = vld_reg[DIV_STG];
    assign out_zbad = zbad_reg[DIV_STG];
    assign quo_x = negx_reg[DIV_STG] ? -$signed({1'b0, nqx_reg[DIV_STG]})
                                     : $signed({1'b0, nqx_reg[DIV_STG]});
    assign quo_y = negy_reg[DIV_STG] ? -$signed({1'b0, nqy_reg[DIV_STG]})
                                     : $signed({1'b0, nqy_reg[DIV_STG]});

endmodule

// File: rtl/core/dpp_mul.sv
module dpp_mul #(
    parameter int SHIFT = dpp_pkg::SH_Q30
) (
    input  logic        aclk,
    input  logic        en,
    input  dpp_pkg::q_t a,
    input  dpp_pkg::q_t b,
    output dpp_pkg::q_t res,
    output logic        sat
);
    import dpp_pkg::*;

    localparam int FW = 124;
    localparam int QW = FW - SHIFT;
    localparam logic [FW-1:0] RND = FW'(1) << (SHIFT - 1);
    localparam logic [QW-1:0] LIMW = QW'(Q_LIM);

    q_t          abs_a;
    q_t          abs_b;
    logic [FW-1:0] full;
    logic        sat_next;
    logic [61:0] mag;

    logic        neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic [61:0] ma_reg, mb_reg;
    logic [61:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic [61:0] p00b_reg, p11b_reg;
    logic [62:0] mid_reg;
    logic [QW-1:0] q_reg;
    q_t          res_reg;
    logic        sat_reg;

    assign abs_a = a[62] ? -a : a;
    assign abs_b = b[62] ? -b : b;

    assign full = {p11b_reg, 62'd0} + {30'd0, mid_reg, 31'd0} + {62'd0, p00b_reg} + RND;

    assign sat_next = q_reg > LIMW;
    assign mag      = sat_next ? Q_LIM[61:0] : q_reg[61:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            neg1_reg <= a[62] ^ b[62];
            ma_reg   <= abs_a[61:0];
            mb_reg   <= abs_b[61:0];

            neg2_reg <= neg1_reg;
            p00_reg  <= ma_reg[30:0]  * mb_reg[30:0];
            p01_reg  <= ma_reg[30:0]  * mb_reg[61:31];
            p10_reg  <= ma_reg[61:31] * mb_reg[30:0];
            p11_reg  <= ma_reg[61:31] * mb_reg[61:31];

            neg3_reg <= neg2_reg;
            mid_reg  <= {1'b0, p01_reg} + {1'b0, p10_reg};
            p00b_reg <= p00_reg;
            p11b_reg <= p11_reg;

            neg4_reg <= neg3_reg;
            q_reg    <= full[FW-1:SHIFT];

            sat_reg  <= sat_next;
            res_reg  <= neg4_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;

endmodule

// File: rtl/core/distorted_pinhole_projection.sv
// Brown-Conrady projection of Q1.30 direction vectors to Q16.16 pixel
// coordinates. One transaction is accepted every clock while the result side
// keeps up; each one passes in turn through the one-bit-per-stage divider for
// x/z and y/z, the multiply/add pipeline (six levels of 5-stage multipliers
// with clamped adds between them), and last through the output
// register. A two-entry output buffer holds results while m_ready is low;
// the pipeline stops only when both entries are full. Registers take writes
// at any time on the cfg channel (always ready), but must only change while
// no transaction is in flight. Status 1 (z not positive) returns zero pixels;
// status 2 flags clamping anywhere along the computation.
module distorted_pinhole_projection (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dpp_pkg::in_t        s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dpp_pkg::out_t       m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  dpp_pkg::cfg_idx_t   cfg_index,
    input  logic [63:0]         cfg_data
);
    import dpp_pkg::*;

    localparam int L    = MUL_LAT;
    localparam int S_A  = 0;
    localparam int K_B  = S_A + L + 1;
    localparam int S_C  = K_B;
    localparam int K_D  = S_C + L + 1;
    localparam int S_E  = K_D;
    localparam int K_F  = S_E + L + 1;
    localparam int S_G  = K_F;
    localparam int K_H  = S_G + L + 1;
    localparam int S_I  = K_H;
    localparam int K_J  = S_I + L + 1;
    localparam int K_K  = K_J + 1;
    localparam int S_L  = K_K;
    localparam int K_M  = S_L + L + 1;
    localparam int NSTG = K_M + 1;

    localparam int M_XX = 0;
    localparam int M_YY = 1;
    localparam int M_XY = 2;
    localparam int M_R4 = 3;
    localparam int M_KR1 = 4;
    localparam int M_R6 = 5;
    localparam int M_KR2 = 6;
    localparam int M_T1 = 7;
    localparam int M_T2 = 8;
    localparam int M_T3 = 9;
    localparam int M_T4 = 10;
    localparam int M_KR3 = 11;
    localparam int M_MX = 12;
    localparam int M_MY = 13;
    localparam int M_PX = 14;
    localparam int M_PY = 15;
    localparam int NMUL = 16;
    localparam logic [NMUL-1:0] MUL_S28 = 16'b0000_1111_1101_0000;

    logic signed [31:0] k1_reg, k2_reg, k3_reg, p1_reg, p2_reg;
    logic [31:0]        fx_reg, fy_reg;
    logic [63:0]        pp_reg;

    logic        en;
    logic        div_vld;
    logic        div_zbad;
    q_t          div_qx;
    q_t          div_qy;

    item_t       pipe_reg  [NSTG];
    item_t       pipe_next [NSTG];
    logic [NSTG-1:0] vld_reg;

    q_t          mul_a   [NMUL];
    q_t          mul_b   [NMUL];
    q_t          mul_res [NMUL];
    logic [NMUL-1:0] mul_sat;

    out_t        last_data;
    logic        last_vld;
    out_t        out_reg;
    out_t        skid_reg;
    logic        out_vld_reg;
    logic        skid_vld_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k1_reg <= '0;
            k2_reg <= '0;
            k3_reg <= '0;
            p1_reg <= '0;
            p2_reg <= '0;
            fx_reg <= FOCAL_RST;
            fy_reg <= FOCAL_RST;
            pp_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_K1: k1_reg <= cfg_data[31:0];
                REG_K2: k2_reg <= cfg_data[31:0];
                REG_K3: k3_reg <= cfg_data[31:0];
                REG_P1: p1_reg <= cfg_data[31:0];
                REG_P2: p2_reg <= cfg_data[31:0];
                REG_FX: fx_reg <= cfg_data[31:0];
                REG_FY: fy_reg <= cfg_data[31:0];
                REG_PP: pp_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advances whenever the output buffer has room
    assign en      = !skid_vld_reg;
    assign s_ready = en;

    dpp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (s_valid),
        .in_zbad  (s_data.dir_z[31] || (s_data.dir_z == 32'sd0)),
        .num_x    (s_data.dir_x),
        .num_y    (s_data.dir_y),
        .den      (s_data.dir_z[30:0]),
        .out_vld  (div_vld),
        .out_zbad (div_zbad),
        .quo_x    (div_qx),
        .quo_y    (div_qy)
    );

    // multiplier operands
    assign mul_a[M_XX]  = pipe_reg[S_A].nx;
    assign mul_b[M_XX]  = pipe_reg[S_A].nx;
    assign mul_a[M_YY]  = pipe_reg[S_A].ny;
    assign mul_b[M_YY]  = pipe_reg[S_A].ny;
    assign mul_a[M_XY]  = pipe_reg[S_A].nx;
    assign mul_b[M_XY]  = pipe_reg[S_A].ny;
    assign mul_a[M_R4]  = pipe_reg[S_C].r2;
    assign mul_b[M_R4]  = pipe_reg[S_C].r2;
    assign mul_a[M_KR1] = sx32(k1_reg);
    assign mul_b[M_KR1] = pipe_reg[S_C].r2;
    assign mul_a[M_R6]  = pipe_reg[S_E].r4;
    assign mul_b[M_R6]  = pipe_reg[S_E].r2;
    assign mul_a[M_KR2] = sx32(k2_reg);
    assign mul_b[M_KR2] = pipe_reg[S_E].r4;
    assign mul_a[M_T1]  = sx32(p1_reg);
    assign mul_b[M_T1]  = pipe_reg[S_E].xy2;
    assign mul_a[M_T2]  = sx32(p2_reg);
    assign mul_b[M_T2]  = pipe_reg[S_E].ax;
    assign mul_a[M_T3]  = sx32(p1_reg);
    assign mul_b[M_T3]  = pipe_reg[S_E].ay;
    assign mul_a[M_T4]  = sx32(p2_reg);
    assign mul_b[M_T4]  = pipe_reg[S_E].xy2;
    assign mul_a[M_KR3] = sx32(k3_reg);
    assign mul_b[M_KR3] = pipe_reg[S_G].r6;
    assign mul_a[M_MX]  = pipe_reg[S_I].nx;
    assign mul_b[M_MX]  = pipe_reg[S_I].rad;
    assign mul_a[M_MY]  = pipe_reg[S_I].ny;
    assign mul_b[M_MY]  = pipe_reg[S_I].rad;
    assign mul_a[M_PX]  = {31'd0, fx_reg};
    assign mul_b[M_PX]  = pipe_reg[S_L].xd;
    assign mul_a[M_PY]  = {31'd0, fy_reg};
    assign mul_b[M_PY]  = pipe_reg[S_L].yd;

    for (genvar g = 0; g < NMUL; g++) begin : g_mul
        dpp_mul #(
            .SHIFT (MUL_S28[g] ? SH_Q28 : SH_Q30)
        ) u_mul (
            .aclk (aclk),
            .en   (en),
            .a    (mul_a[g]),
            .b    (mul_b[g]),
            .res  (mul_res[g]),
            .sat  (mul_sat[g])
        );
    end

    always_comb begin
        sres_t r;
        logic signed [63:0] vx;
        logic signed [63:0] vy;

        pipe_next[0]      = '0;
        pipe_next[0].zbad = div_zbad;
        pipe_next[0].nx   = div_qx;
        pipe_next[0].ny   = div_qy;
        for (int i = 1; i < NSTG; i++) begin
            pipe_next[i] = pipe_reg[i-1];
        end

        // squares and cross term
        pipe_next[K_B].xx  = mul_res[M_XX];
        pipe_next[K_B].yy  = mul_res[M_YY];
        pipe_next[K_B].xy  = mul_res[M_XY];
        pipe_next[K_B].sat = pipe_reg[K_B-1].sat | mul_sat[M_XX] | mul_sat[M_YY]
                             | mul_sat[M_XY];
        r = sadd(mul_res[M_XY], mul_res[M_XY]);
        pipe_next[K_B].xy2 = r.val;
        pipe_next[K_B].sat = pipe_next[K_B].sat | r.sat;
        r = sadd(mul_res[M_XX], mul_res[M_YY]);
        pipe_next[K_B].r2  = r.val;
        pipe_next[K_B].sat = pipe_next[K_B].sat | r.sat;
        r = sadd(mul_res[M_XX], mul_res[M_XX]);
        pipe_next[K_B].txx = r.val;
        pipe_next[K_B].sat = pipe_next[K_B].sat | r.sat;
        r = sadd(mul_res[M_YY], mul_res[M_YY]);
        pipe_next[K_B].tyy = r.val;
        pipe_next[K_B].sat = pipe_next[K_B].sat | r.sat;

        // r4, first radial term, tangential arguments
        pipe_next[K_D].r4  = mul_res[M_R4];
        pipe_next[K_D].sat = pipe_reg[K_D-1].sat | mul_sat[M_R4] | mul_sat[M_KR1];
        r = sadd(Q_ONE, mul_res[M_KR1]);
        pipe_next[K_D].rad = r.val;
        pipe_next[K_D].sat = pipe_next[K_D].sat | r.sat;
        r = sadd(pipe_reg[K_D-1].r2, pipe_reg[K_D-1].txx);
        pipe_next[K_D].ax  = r.val;
        pipe_next[K_D].sat = pipe_next[K_D].sat | r.sat;
        r = sadd(pipe_reg[K_D-1].r2, pipe_reg[K_D-1].tyy);
        pipe_next[K_D].ay  = r.val;
        pipe_next[K_D].sat = pipe_next[K_D].sat | r.sat;

        // r6, second radial term, tangential products
        pipe_next[K_F].r6  = mul_res[M_R6];
        pipe_next[K_F].t1  = mul_res[M_T1];
        pipe_next[K_F].t2  = mul_res[M_T2];
        pipe_next[K_F].t3  = mul_res[M_T3];
        pipe_next[K_F].t4  = mul_res[M_T4];
        pipe_next[K_F].sat = pipe_reg[K_F-1].sat | mul_sat[M_R6] | mul_sat[M_KR2]
                             | mul_sat[M_T1] | mul_sat[M_T2] | mul_sat[M_T3]
                             | mul_sat[M_T4];
        r = sadd(pipe_reg[K_F-1].rad, mul_res[M_KR2]);
        pipe_next[K_F].rad = r.val;
        pipe_next[K_F].sat = pipe_next[K_F].sat | r.sat;

        // third radial term
        r = sadd(pipe_reg[K_H-1].rad, mul_res[M_KR3]);
        pipe_next[K_H].rad = r.val;
        pipe_next[K_H].sat = pipe_reg[K_H-1].sat | mul_sat[M_KR3] | r.sat;

        // distorted point
        pipe_next[K_J].sat = pipe_reg[K_J-1].sat | mul_sat[M_MX] | mul_sat[M_MY];
        r = sadd(mul_res[M_MX], pipe_reg[K_J-1].t1);
        pipe_next[K_J].xd  = r.val;
        pipe_next[K_J].sat = pipe_next[K_J].sat | r.sat;
        r = sadd(mul_res[M_MY], pipe_reg[K_J-1].t3);
        pipe_next[K_J].yd  = r.val;
        pipe_next[K_J].sat = pipe_next[K_J].sat | r.sat;

        r = sadd(pipe_reg[K_K-1].xd, pipe_reg[K_K-1].t2);
        pipe_next[K_K].xd  = r.val;
        pipe_next[K_K].sat = pipe_reg[K_K-1].sat | r.sat;
        r = sadd(pipe_reg[K_K-1].yd, pipe_reg[K_K-1].t4);
        pipe_next[K_K].yd  = r.val;
        pipe_next[K_K].sat = pipe_next[K_K].sat | r.sat;

        // focal scale, principal point, 32-bit clamp
        vx = {mul_res[M_PX][62], mul_res[M_PX]} + {{32{pp_reg[31]}}, pp_reg[31:0]};
        vy = {mul_res[M_PY][62], mul_res[M_PY]} + {{32{pp_reg[63]}}, pp_reg[63:32]};
        pipe_next[K_M].sat = pipe_reg[K_M-1].sat | mul_sat[M_PX] | mul_sat[M_PY];
        if (vx > PIX_MAX) begin
            pipe_next[K_M].px  = PIX_MAX[31:0];
            pipe_next[K_M].sat = 1'b1;
        end else if (vx < PIX_MIN) begin
            pipe_next[K_M].px  = PIX_MIN[31:0];
            pipe_next[K_M].sat = 1'b1;
        end else begin
            pipe_next[K_M].px  = vx[31:0];
        end
        if (vy > PIX_MAX) begin
            pipe_next[K_M].py  = PIX_MAX[31:0];
            pipe_next[K_M].sat = 1'b1;
        end else if (vy < PIX_MIN) begin
            pipe_next[K_M].py  = PIX_MIN[31:0];
            pipe_next[K_M].sat = 1'b1;
        end else begin
            pipe_next[K_M].py  = vy[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], div_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NSTG; i++) begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
    end

    // output buffer
    always_comb begin
        last_vld = vld_reg[NSTG-1];
        if (pipe_reg[NSTG-1].zbad) begin
            last_data.pixel_x = '0;
            last_data.pixel_y = '0;
            last_data.status  = ST_ZNEG;
        end else begin
            last_data.pixel_x = pipe_reg[NSTG-1].px;
            last_data.pixel_y = pipe_reg[NSTG-1].py;
            last_data.status  = pipe_reg[NSTG-1].sat ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!skid_vld_reg) begin
            if (out_vld_reg && !m_ready) begin
                skid_vld_reg <= last_vld;
            end else begin
                out_vld_reg <= last_vld;
            end
        end else if (m_ready) begin
            skid_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_vld_reg) begin
            if (out_vld_reg && !m_ready) begin
                skid_reg <= last_data;
            end else begin
                out_reg <= last_data;
            end
        end else if (m_ready) begin
            out_reg <= skid_reg;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

endmodule

// File: rtl/core/dpp_chk.sv
module dpp_chk (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input dpp_pkg::out_t     m_data,
    input logic              cfg_valid,
    input logic              cfg_ready
);
    import dpp_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result transaction dropped or changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_zneg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_ZNEG) |->
            (m_data.pixel_x == 32'sd0) && (m_data.pixel_y == 32'sd0))
        else $error("nonzero pixel with z not positive");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write not taken");

endmodule

bind distorted_pinhole_projection dpp_chk u_dpp_chk (.*);
